[sv/psi_pkg.sv]
// ----------------------------------------------------------------------------
// psi_pkg
// Shared constants and types for the point set intersection block: default
// sizes, item mode codes and the control group of the reference store.
// ----------------------------------------------------------------------------
package psi_pkg;

   // default sizes handed to the top level parameters
   localparam int STORE_DEPTH_DEF = 64;
   localparam int COORD_WIDTH_DEF = 16;

   // width of a coordinate field on the ports
   localparam int FIELD_WIDTH = 16;

   // item mode codes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_PROBE = 1'b1;

   // strobes from the scan control to the reference store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

[sv/psi_store.sv]
// ----------------------------------------------------------------------------
// psi_store
// Reference point store: one write port, one read port with registered
// read data. The read data holds while no read is issued.
// ----------------------------------------------------------------------------
module psi_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 48,
   parameter int AW    = 6
) (
   input  logic                 clock,
   input  psi_pkg::mem_ctl_type ctl,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [AW-1:0]        rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   import psi_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write an appended point
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read one entry, hold the data otherwise
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/point_set_intersection.sv]
// ----------------------------------------------------------------------------
// point_set_intersection
// Keeps a store of reference 3D points and reports, for each probe point,
// one result per stored entry equal to it, the last one marked final.
//
//   channel  direction  ports
//   req      in         req_valid/req_ready, mode, start_new, px, py, pz
//   rsp      out        rsp_valid/rsp_ready, cx, cy, cz, final_match
//
// A load, or a probe of an empty store, is done once it is accepted. Any other
// probe goes through the accept, one read a cycle per entry while results drain
// freely, the compare of the last entry and the final result, if there is one.
// Reset empties the store at once (the count goes to zero).
// A stalled result port holds the scan at the next match; a result waits
// in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module point_set_intersection #(
   parameter int STORE_DEPTH = psi_pkg::STORE_DEPTH_DEF,
   parameter int COORD_WIDTH = psi_pkg::COORD_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic                                 req_start_new,
   input  logic signed [psi_pkg::FIELD_WIDTH-1:0] req_px,
   input  logic signed [psi_pkg::FIELD_WIDTH-1:0] req_py,
   input  logic signed [psi_pkg::FIELD_WIDTH-1:0] req_pz,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [psi_pkg::FIELD_WIDTH-1:0] rsp_cx,
   output logic signed [psi_pkg::FIELD_WIDTH-1:0] rsp_cy,
   output logic signed [psi_pkg::FIELD_WIDTH-1:0] rsp_cz,
   output logic                                 rsp_final_match
);
   import psi_pkg::*;

   localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
   localparam int AW      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int ENTRY_W = 3 * COORD_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] fet_idx_ff, fet_idx_in;
   logic        cmp_vld_ff, cmp_vld_in;
   logic        pending_ff, pending_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_final_ff;

   logic signed [COORD_WIDTH-1:0] probe_x_ff, probe_y_ff, probe_z_ff;
   logic signed [COORD_WIDTH-1:0] in_x, in_y, in_z;
   logic signed [FIELD_WIDTH-1:0] rsp_cx_ff, rsp_cy_ff, rsp_cz_ff;

   mem_ctl_type      mem_ctl;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;

   logic out_free, hit, stall, emit, emit_final, probe_load;

   // wrap the input fields to the stored coordinate width
   assign in_x    = COORD_WIDTH'(req_px);
   assign in_y    = COORD_WIDTH'(req_py);
   assign in_z    = COORD_WIDTH'(req_pz);
   assign wr_data = {in_x, in_y, in_z};

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign hit       = (rd_data == {probe_x_ff, probe_y_ff, probe_z_ff});
   assign stall     = cmp_vld_ff && hit && pending_ff && !out_free;
   assign req_ready = (state_ff == ST_IDLE);

   psi_store #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (ENTRY_W),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequence loads, the store scan and the final result
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      fet_idx_in = fet_idx_ff;
      cmp_vld_in = cmp_vld_ff;
      pending_in = pending_ff;
      mem_ctl    = '0;
      wr_addr    = count_ff[AW-1:0];
      rd_addr    = fet_idx_ff[AW-1:0];
      emit       = 1'b0;
      emit_final = 1'b0;
      probe_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_PROBE) begin
                  probe_load = 1'b1;
                  fet_idx_in = '0;
                  cmp_vld_in = 1'b0;
                  if (count_ff != '0) begin
                     state_in = ST_SCAN;
                  end
               end else if (req_start_new) begin
                  mem_ctl.wr_en = 1'b1;
                  wr_addr       = '0;
                  count_in      = CNT_W'(1);
               end else if (count_ff < CNT_W'(STORE_DEPTH)) begin
                  // append; drop the load when the store is full
                  mem_ctl.wr_en = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
               end
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               // a new match releases the one held back as not final
               if (cmp_vld_ff && hit) begin
                  emit       = pending_ff;
                  pending_in = 1'b1;
               end
               // fetch the next entry or finish the walk
               if (fet_idx_ff < count_ff) begin
                  mem_ctl.rd_en = 1'b1;
                  fet_idx_in    = fet_idx_ff + CNT_W'(1);
                  cmp_vld_in    = 1'b1;
               end else begin
                  cmp_vld_in = 1'b0;
                  state_in   = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pending_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               emit       = 1'b1;
               emit_final = 1'b1;
               pending_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // advance the output register on a result, drop it on a transfer
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         fet_idx_ff   <= '0;
         cmp_vld_ff   <= 1'b0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fet_idx_ff   <= fet_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture the probe point and the result payload
   always_ff @(posedge clock) begin
      if (probe_load) begin
         probe_x_ff <= in_x;
         probe_y_ff <= in_y;
         probe_z_ff <= in_z;
      end
      if (emit) begin
         rsp_cx_ff    <= FIELD_WIDTH'(probe_x_ff);
         rsp_cy_ff    <= FIELD_WIDTH'(probe_y_ff);
         rsp_cz_ff    <= FIELD_WIDTH'(probe_z_ff);
         rsp_final_ff <= emit_final;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cx          = rsp_cx_ff;
   assign rsp_cy          = rsp_cy_ff;
   assign rsp_cz          = rsp_cz_ff;
   assign rsp_final_match = rsp_final_ff;

   // no match may be held back once the block is idle again
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pending_ff)
      else $error("match left pending in idle");

   // the entry count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STORE_DEPTH))
      else $error("stored count beyond depth");

   // read data is only compared during a scan
   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> state_ff == ST_SCAN)
      else $error("compare stage valid outside scan");

   // the fetch pointer stays inside the filled part of the store
   a_fetch_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> fet_idx_ff <= count_ff)
      else $error("fetch beyond stored entries");

   // a stalled result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result overwritten while waiting");

endmodule

[test/point_set_intersection_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_set_intersection_tb
// Self-checking bench for the point set intersection block. A queue of
// load and probe items feeds a bursty driver. A shadow copy of the
// reference store predicts every common point, and a monitor with its own
// stall pattern checks each result transfer in order. One long receiver
// hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module point_set_intersection_tb;

   localparam int DEPTH       = psi_pkg::STORE_DEPTH_DEF;
   localparam int CW          = psi_pkg::COORD_WIDTH_DEF;
   localparam int FW          = psi_pkg::FIELD_WIDTH;
   localparam int IDLE_LIMIT  = 4000;
   localparam int DRAIN_CYC   = 2 * DEPTH + 10;
   localparam int HOLD_CYC    = 400;
   localparam int ITEM_TARGET = 270;

   typedef logic [3*FW-1:0] point_type;

   typedef struct {
      logic                 mode;
      logic                 start_new;
      logic signed [FW-1:0] px;
      logic signed [FW-1:0] py;
      logic signed [FW-1:0] pz;
   } point_item_type;

   typedef struct {
      logic signed [FW-1:0] cx;
      logic signed [FW-1:0] cy;
      logic signed [FW-1:0] cz;
      logic                 final_match;
   } match_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_mode = psi_pkg::MODE_LOAD;
   logic                 req_start_new = 1'b0;
   logic signed [FW-1:0] req_px = '0;
   logic signed [FW-1:0] req_py = '0;
   logic signed [FW-1:0] req_pz = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [FW-1:0] rsp_cx;
   logic signed [FW-1:0] rsp_cy;
   logic signed [FW-1:0] rsp_cz;
   logic                 rsp_final_match;

   point_item_type pending_items[$];
   match_type      expected_matches[$];
   int             errors = 0;

   // shadow of the reference store
   logic [3*CW-1:0] shadow_pts [DEPTH];
   int              shadow_count = 0;

   point_set_intersection dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_start_new   (req_start_new),
      .req_px          (req_px),
      .req_py          (req_py),
      .req_pz          (req_pz),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cx          (rsp_cx),
      .rsp_cy          (rsp_cy),
      .rsp_cz          (rsp_cz),
      .rsp_final_match (rsp_final_match)
   );

   always #10 clock = ~clock;

   // wrap a sign-extended field to the stored coordinate width
   function automatic logic [CW-1:0] to_coord(input logic signed [FW-1:0] f);
      logic signed [31:0] ext;
      ext = f;
      return ext[CW-1:0];
   endfunction

   // sign-extend a stored coordinate back to the port width
   function automatic logic signed [FW-1:0] from_coord(input logic [CW-1:0] c);
      logic signed [CW-1:0] s;
      logic signed [31:0]   ext;
      s   = c;
      ext = s;
      return ext[FW-1:0];
   endfunction

   // update the shadow store and queue the common points of a probe
   function automatic void predict_matches(input point_item_type it);
      logic [3*CW-1:0] key;
      match_type       m;
      int              hits;
      int              k;
      key = {to_coord(it.px), to_coord(it.py), to_coord(it.pz)};
      if (it.mode == psi_pkg::MODE_LOAD) begin
         if (it.start_new)
            shadow_count = 0;
         if (shadow_count < DEPTH) begin
            shadow_pts[shadow_count] = key;
            shadow_count++;
         end
      end else begin
         hits = 0;
         for (int i = 0; i < shadow_count; i++)
            if (shadow_pts[i] == key)
               hits++;
         m.cx = from_coord(key[3*CW-1:2*CW]);
         m.cy = from_coord(key[2*CW-1:CW]);
         m.cz = from_coord(key[CW-1:0]);
         for (k = 1; k <= hits; k++) begin
            m.final_match = (k == hits);
            expected_matches = {expected_matches, m};
         end
      end
   endfunction

   function automatic void add_point(input logic mode, input logic start_new,
                                     input point_type pt);
      point_item_type it;
      it.mode      = mode;
      it.start_new = start_new;
      it.px        = pt[3*FW-1:2*FW];
      it.py        = pt[2*FW-1:FW];
      it.pz        = pt[FW-1:0];
      pending_items = {pending_items, it};
   endfunction

   // random coordinate, with the extremes drawn often
   function automatic logic [FW-1:0] rand_coord();
      logic [31:0] r;
      r = $urandom;
      case (r[3:0])
         4'd0:    return 16'h8000;
         4'd1:    return 16'h7fff;
         4'd2:    return 16'h0000;
         4'd3:    return 16'hffff;
         default: return r[31:16];
      endcase
   endfunction

   function automatic point_type rand_point();
      return {rand_coord(), rand_coord(), rand_coord()};
   endfunction

   function automatic void check_field(input string name,
                                       input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // driver: bursts of transfers with random gaps between them
   point_item_type cur_item;
   int             burst_left = 0;
   int             gap_left   = 0;
   logic           next_valid;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            predict_matches(cur_item);
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0) begin
               if (burst_left == 0)
                  burst_left = $urandom_range(1, 12);
               cur_item = pending_items.pop_front();
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 9);
               next_valid    = 1'b1;
               req_mode      <= cur_item.mode;
               req_start_new <= cur_item.start_new;
               req_px        <= cur_item.px;
               req_py        <= cur_item.py;
               req_pz        <= cur_item.pz;
            end
         end
         req_valid <= next_valid;
      end
   end

   // monitor: check each result transfer and pace rsp_ready
   match_type got_match;
   match_type want_match;
   int        results_seen = 0;
   int        hold_left    = 0;
   logic      hold_done    = 1'b0;
   logic      stalling     = 1'b0;
   int        phase_left   = 0;
   logic      next_ready;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_match.cx          = rsp_cx;
            got_match.cy          = rsp_cy;
            got_match.cz          = rsp_cz;
            got_match.final_match = rsp_final_match;
            if (expected_matches.size() == 0) begin
               $error("unexpected result (%0d, %0d, %0d) final %0d",
                      got_match.cx, got_match.cy, got_match.cz, got_match.final_match);
               errors++;
            end else begin
               want_match = expected_matches.pop_front();
               check_field("cx", 32'(want_match.cx), 32'(got_match.cx));
               check_field("cy", 32'(want_match.cy), 32'(got_match.cy));
               check_field("cz", 32'(want_match.cz), 32'(got_match.cz));
               check_field("final_match", 32'(want_match.final_match),
                           32'(got_match.final_match));
            end
            results_seen++;
         end
         // one long hold-off to back the block up, then the usual pattern
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (!hold_done && results_seen >= 30) begin
            hold_done  = 1'b1;
            hold_left  = HOLD_CYC - 1;
            next_ready = 1'b0;
         end else begin
            if (phase_left == 0) begin
               stalling = ~stalling;
               if (stalling)
                  phase_left = $urandom_range(1, 6);
               else if ($urandom_range(0, 3) == 0)
                  phase_left = $urandom_range(30, 80);
               else
                  phase_left = $urandom_range(1, 8);
            end
            phase_left--;
            next_ready = !stalling;
         end
         rsp_ready <= next_ready;
      end
   end

   // watchdog: end the run when no transfer happens for too long
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("point_set_intersection_tb: done, errors");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : stimulus
      point_type pool[$];
      point_type pt;
      point_type other;
      int        n_loads;
      int        n_probes;
      int        sel;

      // directed: empty store, extremes, duplicates, partial matches, restart
      add_point(psi_pkg::MODE_PROBE, 1'b1, {16'h0000, 16'h0000, 16'h0000});
      add_point(psi_pkg::MODE_LOAD, 1'b1, {16'h8000, 16'h8000, 16'h8000});
      add_point(psi_pkg::MODE_LOAD, 1'b0, {16'h7fff, 16'h7fff, 16'h7fff});
      add_point(psi_pkg::MODE_LOAD, 1'b0, {16'h0000, 16'h0000, 16'h0000});
      add_point(psi_pkg::MODE_LOAD, 1'b0, {16'hffff, 16'hffff, 16'hffff});
      add_point(psi_pkg::MODE_LOAD, 1'b0, {16'h7fff, 16'h7fff, 16'h7fff});
      add_point(psi_pkg::MODE_PROBE, 1'b0, {16'h7fff, 16'h7fff, 16'h7fff});
      add_point(psi_pkg::MODE_PROBE, 1'b1, {16'h8000, 16'h8000, 16'h8000});
      add_point(psi_pkg::MODE_PROBE, 1'b0, {16'h0000, 16'h0000, 16'h0000});
      add_point(psi_pkg::MODE_PROBE, 1'b0, {16'hffff, 16'hffff, 16'hffff});
      add_point(psi_pkg::MODE_PROBE, 1'b0, {16'hffff, 16'hffff, 16'h0000});
      add_point(psi_pkg::MODE_PROBE, 1'b0, {16'h0000, 16'h0000, 16'h0001});
      add_point(psi_pkg::MODE_PROBE, 1'b0, {16'h8000, 16'h7fff, 16'h0000});
      add_point(psi_pkg::MODE_LOAD, 1'b1, {16'h5555, 16'haaaa, 16'h1234});
      add_point(psi_pkg::MODE_PROBE, 1'b0, {16'h7fff, 16'h7fff, 16'h7fff});
      add_point(psi_pkg::MODE_PROBE, 1'b0, {16'h5555, 16'haaaa, 16'h1234});
      add_point(psi_pkg::MODE_LOAD, 1'b0, {16'h8000, 16'h7fff, 16'hffff});
      add_point(psi_pkg::MODE_PROBE, 1'b0, {16'h8000, 16'h7fff, 16'hffff});

      // full store: one point in every entry, then dropped and restarting loads
      pt    = rand_point();
      other = pt ^ {16'h0001, 32'h0};
      add_point(psi_pkg::MODE_LOAD, 1'b1, pt);
      for (int i = 1; i < DEPTH; i++)
         add_point(psi_pkg::MODE_LOAD, 1'b0, pt);
      add_point(psi_pkg::MODE_LOAD, 1'b0, other);
      add_point(psi_pkg::MODE_LOAD, 1'b0, other);
      add_point(psi_pkg::MODE_PROBE, 1'b0, pt);
      add_point(psi_pkg::MODE_PROBE, 1'b0, other);
      add_point(psi_pkg::MODE_LOAD, 1'b1, other);
      add_point(psi_pkg::MODE_PROBE, 1'b0, other);
      add_point(psi_pkg::MODE_PROBE, 1'b0, pt);

      // random: mostly load-then-probe sequences, some noise and appends
      while (pending_items.size() < ITEM_TARGET) begin
         if ($urandom_range(0, 7) == 0) begin
            for (int i = $urandom_range(1, 4); i > 0; i--)
               add_point(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         rand_point());
         end else begin
            pool.delete();
            n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24)
                                                  : $urandom_range(1, 10);
            for (int i = 0; i < n_loads; i++) begin
               if (pool.size() > 0 && $urandom_range(0, 9) < 3)
                  pt = pool[$urandom_range(0, pool.size() - 1)];
               else
                  pt = rand_point();
               pool = {pool, pt};
               // an append to the previous set now and then
               add_point(psi_pkg::MODE_LOAD,
                         (i == 0) && ($urandom_range(0, 4) != 0), pt);
            end
            n_probes = $urandom_range(1, 6);
            for (int i = 0; i < n_probes; i++) begin
               sel = $urandom_range(0, 9);
               pt  = pool[$urandom_range(0, pool.size() - 1)];
               if (sel >= 8)
                  pt = rand_point();
               else if (sel >= 6)
                  pt = pt ^ (point_type'(1) << $urandom_range(0, 3 * FW - 1));
               add_point(psi_pkg::MODE_PROBE, 1'($urandom_range(0, 1)), pt);
            end
         end
      end

      // hold reset, then release it
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // drain: all items sent, all results seen, then let a last scan finish
      while (pending_items.size() != 0 || req_valid || expected_matches.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYC) @(negedge clock);
      if (expected_matches.size() != 0) begin
         $error("%0d expected results never arrived", expected_matches.size());
         errors++;
      end
      if (errors == 0)
         $display("point_set_intersection_tb: done, clean");
      else
         $display("point_set_intersection_tb: done, errors");
      $finish;
   end

endmodule
